// ===== rtl/moment_accumulator_table_core_assert.svh =====
// Assertion macros for the checker file.
`ifndef MOMENT_ACCUMULATOR_TABLE_CORE_ASSERT_SVH
`define MOMENT_ACCUMULATOR_TABLE_CORE_ASSERT_SVH

// Check a property outside reset.
`define MAT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every edge, reset included.
`define MAT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/mat_pkg.sv =====
`default_nettype none
package mat_pkg;

  localparam logic [1:0] CMD_ACC   = 2'd0;
  localparam logic [1:0] CMD_MERGE = 2'd1;
  localparam logic [1:0] CMD_FIN   = 2'd2;

  localparam int SUM_W   = 40;
  localparam int SUMSQ_W = 64;
  localparam int OUT_W   = 40;
  localparam int N_W     = 16;
  localparam int VAL_W   = 24;
  localparam int SP_W    = 8;
  localparam int EL_W    = 2;

  localparam int PROD_W = 80;
  localparam int DVD_W  = 112;
  localparam int DVS_W  = 48;
  localparam int ROOT_W = 56;

  localparam int MUL_STEPS  = 40;
  localparam int DIV_STEPS  = 112;
  localparam int ROOT_STEPS = 56;

  typedef enum logic {MUL_NQ, MUL_SS} mul_sel_t;
  typedef enum logic [1:0] {DIV_MEAN, DIV_VAR, DIV_SE} div_sel_t;

  typedef struct packed {
    logic     clr_step;
    logic     req_load;
    logic     upd;
    logic     fin_load;
    logic     mul_start;
    mul_sel_t mul_sel;
    logic     cap_nq;
    logic     cap_dev;
    logic     div_start;
    div_sel_t div_sel;
    logic     cap_mean;
    logic     cap_var;
    logic     root_start;
    logic     cap_se;
    logic     out_load;
  } mat_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic req_ok;
    logic req_fin;
    logic mul_done;
    logic div_done;
    logic root_done;
  } mat_status_t;

endpackage
`default_nettype wire

// ===== rtl/mat_if.sv =====
`default_nettype none
interface mat_in_if import mat_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           command;
  logic [SP_W-1:0]      sample_point;
  logic [EL_W-1:0]      element;
  logic [VAL_W-1:0]     value;
  logic [SUM_W-1:0]     partial_sum;
  logic [SUMSQ_W-1:0]   partial_sumsq;

  modport source (output valid, command, sample_point, element, value, partial_sum,
                  partial_sumsq, input ready);
  modport sink (input valid, command, sample_point, element, value, partial_sum,
                partial_sumsq, output ready);
endinterface

interface mat_out_if import mat_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OUT_W-1:0]   mean_q16;
  logic [SUMSQ_W-1:0] variance_q16;
  logic [OUT_W-1:0]   std_error_q16;
  logic               saturated;

  modport source (output valid, mean_q16, variance_q16, std_error_q16, saturated,
                  input ready);
  modport sink (input valid, mean_q16, variance_q16, std_error_q16, saturated,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/moment_accumulator_table_core.sv =====
// Accumulate and merge: a table read, a read-modify-write and an output load, which
// waits while the previous result is stalled; a request with an out-of-range index or
// unknown command goes straight to the output load. Finalize runs the serial units in
// turn: two 40-step multiplies, three 112-step divides and a 56-step square root.
// Reset (synchronous, active high) clears all NUM_SAMPLES*VECTOR_LENGTH entries (1024 by
// default) in a pass during which no request is accepted; path_count resets to 1.
`default_nettype none
module moment_accumulator_table_core import mat_pkg::*; #(
  parameter int NUM_SAMPLES   = 256,
  parameter int VECTOR_LENGTH = 4,
  parameter int VALUE_BITS    = 24
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_we,
  input  wire logic [N_W-1:0] cfg_data,
  mat_in_if.sink              item_in,
  mat_out_if.source           item_out
);

  // Controller sequences the table access and the serial arithmetic units;
  // datapath holds the table, path count, units and the result registers.
  mat_cmd_t    cmd;
  mat_status_t st;

  mat_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item_in.valid),
    .in_ready  (item_in.ready),
    .out_valid (item_out.valid),
    .out_ready (item_out.ready),
    .st        (st),
    .cmd       (cmd)
  );

  // Output register parts the two sides: a new request is taken while the
  // previous result still waits for its consumer.
  mat_dp #(
    .NUM_SAMPLES   (NUM_SAMPLES),
    .VECTOR_LENGTH (VECTOR_LENGTH),
    .VALUE_BITS    (VALUE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .command       (item_in.command),
    .sample_point  (item_in.sample_point),
    .element       (item_in.element),
    .value         (item_in.value),
    .partial_sum   (item_in.partial_sum),
    .partial_sumsq (item_in.partial_sumsq),
    .cmd           (cmd),
    .st            (st),
    .mean_q16      (item_out.mean_q16),
    .variance_q16  (item_out.variance_q16),
    .std_error_q16 (item_out.std_error_q16),
    .saturated     (item_out.saturated)
  );

endmodule
`default_nettype wire

// ===== rtl/mat_ctrl.sv =====
`default_nettype none
module mat_ctrl import mat_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  input  wire mat_status_t st,
  output mat_cmd_t         cmd
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_LOAD, S_MUL_NQ, S_MUL_SS,
    S_DIV_MEAN, S_DIV_VAR, S_DIV_SE, S_ROOT, S_DONE
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.mul_sel    = MUL_NQ;
    cmd.div_sel    = DIV_MEAN;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.req_load = 1'b1;
          state_next   = S_READ;
        end
      end
      S_READ: begin
        state_next = st.req_ok ? S_LOAD : S_DONE;
      end
      S_LOAD: begin
        if (st.req_fin) begin
          cmd.fin_load  = 1'b1;
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MUL_NQ;
          state_next    = S_MUL_NQ;
        end else begin
          cmd.upd    = 1'b1;
          state_next = S_DONE;
        end
      end
      S_MUL_NQ: begin
        if (st.mul_done) begin
          cmd.cap_nq    = 1'b1;
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MUL_SS;
          state_next    = S_MUL_SS;
        end
      end
      S_MUL_SS: begin
        if (st.mul_done) begin
          cmd.cap_dev   = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_MEAN;
          state_next    = S_DIV_MEAN;
        end
      end
      S_DIV_MEAN: begin
        if (st.div_done) begin
          cmd.cap_mean  = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_VAR;
          state_next    = S_DIV_VAR;
        end
      end
      S_DIV_VAR: begin
        if (st.div_done) begin
          cmd.cap_var   = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_SE;
          state_next    = S_DIV_SE;
        end
      end
      S_DIV_SE: begin
        if (st.div_done) begin
          cmd.root_start = 1'b1;
          state_next     = S_ROOT;
        end
      end
      S_ROOT: begin
        if (st.root_done) begin
          cmd.cap_se = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/mat_dp.sv =====
`default_nettype none
module mat_dp import mat_pkg::*; #(
  parameter int NUM_SAMPLES   = 256,
  parameter int VECTOR_LENGTH = 4,
  parameter int VALUE_BITS    = 24
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [N_W-1:0]     cfg_data,
  input  wire logic [1:0]         command,
  input  wire logic [SP_W-1:0]    sample_point,
  input  wire logic [EL_W-1:0]    element,
  input  wire logic [VAL_W-1:0]   value,
  input  wire logic [SUM_W-1:0]   partial_sum,
  input  wire logic [SUMSQ_W-1:0] partial_sumsq,
  input  wire mat_cmd_t           cmd,
  output mat_status_t             st,
  output logic [OUT_W-1:0]        mean_q16,
  output logic [SUMSQ_W-1:0]      variance_q16,
  output logic [OUT_W-1:0]        std_error_q16,
  output logic                    saturated
);

  localparam int ENTRIES = NUM_SAMPLES * VECTOR_LENGTH;
  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int ROW_W   = 1 + SUMSQ_W + SUM_W;
  localparam logic [VAL_W-1:0] VAL_MASK = VAL_W'((64'd1 << VALUE_BITS) - 64'd1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(ENTRIES - 1);

  // request
  logic [1:0]         req_cmd;
  logic [AW-1:0]      req_idx;
  logic               req_ok;
  logic [VAL_W-1:0]   req_val;
  logic [SUM_W-1:0]   req_psum;
  logic [SUMSQ_W-1:0] req_psq;
  logic [31:0]        idx_full;
  logic               idx_ok;
  logic [2*VAL_W-1:0] sq;

  assign idx_full = 32'(sample_point) * 32'(VECTOR_LENGTH) + 32'(element);
  assign idx_ok   = (32'(sample_point) < 32'(NUM_SAMPLES)) &&
                    (32'(element) < 32'(VECTOR_LENGTH));

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req_cmd  <= command;
      req_idx  <= idx_ok ? idx_full[AW-1:0] : '0;
      req_ok   <= idx_ok && (command != 2'd3);
      req_val  <= value & VAL_MASK;
      req_psum <= partial_sum;
      req_psq  <= partial_sumsq;
    end
    sq <= (2*VAL_W)'(req_val) * (2*VAL_W)'(req_val);
  end

  // table memory
  logic [ROW_W-1:0] mem [ENTRIES];
  logic [ROW_W-1:0] rd_row, wr_row;
  logic [AW-1:0]    wr_addr, clr_addr;
  logic             wr_en;
  logic [SUM_W-1:0]   rd_sum, add_s, s_new, up_s;
  logic [SUMSQ_W-1:0] rd_q, add_q, q_new, up_q;
  logic               rd_flag, s_c, q_c, flag_new;

  assign rd_sum  = rd_row[SUM_W-1:0];
  assign rd_q    = rd_row[SUM_W +: SUMSQ_W];
  assign rd_flag = rd_row[ROW_W-1];

  always_comb begin
    add_s        = (req_cmd == CMD_ACC) ? SUM_W'(req_val) : req_psum;
    add_q        = (req_cmd == CMD_ACC) ? SUMSQ_W'(sq) : req_psq;
    {s_c, s_new} = {1'b0, rd_sum} + {1'b0, add_s};
    {q_c, q_new} = {1'b0, rd_q} + {1'b0, add_q};
    up_s         = s_c ? '1 : s_new;
    up_q         = q_c ? '1 : q_new;
    flag_new     = rd_flag | s_c | q_c;
    wr_en        = cmd.clr_step | cmd.upd;
    wr_addr      = cmd.clr_step ? clr_addr : req_idx;
    wr_row       = cmd.clr_step ? '0 : {flag_new, up_q, up_s};
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_row;
    rd_row <= mem[req_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (cmd.clr_step) clr_addr <= clr_addr + 1'b1;
  end

  // path count and its powers
  logic [N_W-1:0]   pc, n;
  logic [2*N_W-1:0] n2;
  logic [DVS_W-1:0] n3;

  always_ff @(posedge clk) begin
    if (rst) pc <= N_W'(1);
    else if (cfg_we) pc <= cfg_data;
    n2 <= (2*N_W)'(n) * (2*N_W)'(n);
    n3 <= DVS_W'(n2) * DVS_W'(n);
  end
  assign n = (pc == '0) ? N_W'(1) : pc;

  // shift-add multiplier
  logic [PROD_W-1:0] mul_a, mul_acc, nq, dev;
  logic [SUM_W-1:0]  mul_b;
  logic [5:0]        mul_cnt;
  logic              mul_busy, mul_done, dev_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_busy <= 1'b0;
      mul_done <= 1'b0;
    end else begin
      mul_done <= 1'b0;
      if (cmd.mul_start) begin
        mul_a    <= (cmd.mul_sel == MUL_NQ) ? PROD_W'(rd_q) : PROD_W'(rd_sum);
        mul_b    <= (cmd.mul_sel == MUL_NQ) ? SUM_W'(n) : rd_sum;
        mul_acc  <= '0;
        mul_cnt  <= '0;
        mul_busy <= 1'b1;
      end else if (mul_busy) begin
        if (mul_b[0]) mul_acc <= mul_acc + mul_a;
        mul_a   <= {mul_a[PROD_W-2:0], 1'b0};
        mul_b   <= {1'b0, mul_b[SUM_W-1:1]};
        mul_cnt <= mul_cnt + 1'b1;
        if (mul_cnt == 6'(MUL_STEPS - 1)) begin
          mul_busy <= 1'b0;
          mul_done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_nq) nq <= mul_acc;
    if (cmd.cap_dev) begin
      dev_neg <= nq < mul_acc;
      dev     <= nq - mul_acc;
    end
  end

  // restoring divider, one quotient bit a cycle
  logic [DVD_W-1:0] div_q;
  logic [DVS_W-1:0] div_r, div_d;
  logic [DVS_W:0]   rem_sh, rem_dif;
  logic [6:0]       div_cnt;
  logic             div_busy, div_done, div_ge;

  assign rem_sh  = {div_r, div_q[DVD_W-1]};
  assign rem_dif = rem_sh - {1'b0, div_d};
  assign div_ge  = rem_sh >= {1'b0, div_d};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_done <= 1'b0;
    end else begin
      div_done <= 1'b0;
      if (cmd.div_start) begin
        div_r    <= '0;
        div_cnt  <= '0;
        div_busy <= 1'b1;
        if (cmd.div_sel == DIV_MEAN) begin
          div_q <= DVD_W'({rd_sum, 16'b0});
          div_d <= DVS_W'(n);
        end else if (cmd.div_sel == DIV_VAR) begin
          div_q <= DVD_W'({dev, 16'b0});
          div_d <= DVS_W'(n2);
        end else begin
          div_q <= {dev, 32'b0};
          div_d <= n3;
        end
      end else if (div_busy) begin
        div_r   <= div_ge ? rem_dif[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        div_q   <= {div_q[DVD_W-2:0], div_ge};
        div_cnt <= div_cnt + 1'b1;
        if (div_cnt == 7'(DIV_STEPS - 1)) begin
          div_busy <= 1'b0;
          div_done <= 1'b1;
        end
      end
    end
  end

  // digit-by-digit square root, one root bit a cycle
  logic [DVD_W-1:0]  rt_rad;
  logic [ROOT_W+1:0] rt_rem;
  logic [ROOT_W-1:0] rt_root;
  logic [ROOT_W+3:0] rt_sh, rt_trial, rt_dif;
  logic [5:0]        rt_cnt;
  logic              rt_busy, rt_done, rt_ge;

  assign rt_sh    = {rt_rem, rt_rad[DVD_W-1 -: 2]};
  assign rt_trial = {2'b00, rt_root, 2'b01};
  assign rt_dif   = rt_sh - rt_trial;
  assign rt_ge    = rt_sh >= rt_trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      rt_busy <= 1'b0;
      rt_done <= 1'b0;
    end else begin
      rt_done <= 1'b0;
      if (cmd.root_start) begin
        rt_rad  <= div_q;
        rt_rem  <= '0;
        rt_root <= '0;
        rt_cnt  <= '0;
        rt_busy <= 1'b1;
      end else if (rt_busy) begin
        rt_rad  <= {rt_rad[DVD_W-3:0], 2'b00};
        rt_rem  <= rt_ge ? rt_dif[ROOT_W+1:0] : rt_sh[ROOT_W+1:0];
        rt_root <= {rt_root[ROOT_W-2:0], rt_ge};
        rt_cnt  <= rt_cnt + 1'b1;
        if (rt_cnt == 6'(ROOT_STEPS - 1)) begin
          rt_busy <= 1'b0;
          rt_done <= 1'b1;
        end
      end
    end
  end

  // result and output registers
  logic [OUT_W-1:0]   res_mean, res_se;
  logic [SUMSQ_W-1:0] res_var;
  logic               res_flag;

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      res_mean <= '0;
      res_var  <= '0;
      res_se   <= '0;
      res_flag <= 1'b0;
    end
    if (cmd.upd) res_flag <= flag_new;
    if (cmd.fin_load) res_flag <= rd_flag;
    if (cmd.cap_mean) res_mean <= (|div_q[DVD_W-1:OUT_W]) ? '1 : div_q[OUT_W-1:0];
    if (cmd.cap_var)
      res_var <= dev_neg ? '0 :
                 ((|div_q[DVD_W-1:SUMSQ_W]) ? '1 : div_q[SUMSQ_W-1:0]);
    if (cmd.cap_se)
      res_se <= dev_neg ? '0 :
                ((|rt_root[ROOT_W-1:OUT_W]) ? '1 : rt_root[OUT_W-1:0]);
    if (cmd.out_load) begin
      mean_q16      <= res_mean;
      variance_q16  <= res_var;
      std_error_q16 <= res_se;
      saturated     <= res_flag;
    end
  end

  assign st.clr_last  = clr_addr == LAST_ADDR;
  assign st.req_ok    = req_ok;
  assign st.req_fin   = req_cmd == CMD_FIN;
  assign st.mul_done  = mul_done;
  assign st.div_done  = div_done;
  assign st.root_done = rt_done;

endmodule
`default_nettype wire

// ===== rtl/moment_accumulator_table_core_checker.sv =====
`default_nettype none
`include "moment_accumulator_table_core_assert.svh"
module moment_accumulator_table_core_checker import mat_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [OUT_W-1:0]   mean_q16,
  input wire logic [SUMSQ_W-1:0] variance_q16,
  input wire logic [OUT_W-1:0]   std_error_q16,
  input wire logic               saturated
);

  // clearing pass holds off requests right after reset
  `MAT_ASSERT_ALWAYS(a_rst_no_ready, clk, rst |=> !in_ready, "ready right after reset")
  `MAT_ASSERT_ALWAYS(a_rst_no_valid, clk, rst |=> !out_valid, "valid right after reset")
  `MAT_ASSERT(a_one_at_a_time, clk, rst, in_valid && in_ready |=> !in_ready,
              "second request taken while busy")
  `MAT_ASSERT(a_out_hold, clk, rst,
              out_valid && !out_ready |=> out_valid && $stable(mean_q16) &&
              $stable(variance_q16) && $stable(std_error_q16) && $stable(saturated),
              "stalled result changed")

endmodule

bind moment_accumulator_table_core moment_accumulator_table_core_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (item_in.valid),
  .in_ready      (item_in.ready),
  .out_valid     (item_out.valid),
  .out_ready     (item_out.ready),
  .mean_q16      (item_out.mean_q16),
  .variance_q16  (item_out.variance_q16),
  .std_error_q16 (item_out.std_error_q16),
  .saturated     (item_out.saturated)
);
`default_nettype wire
